### hdl/rtni_pkg.sv
// Package for the ranked top-N insertion lists: sizes, payload structs,
// request codes and the reset name table. No dependencies.
`timescale 1ns / 1ps

package rtni_pkg;

   localparam int LIST_DEPTH = 8;
   localparam int LIST_COUNT = 3;
   localparam int SCORE_STEP = 1000;

   localparam int SCORE_W = 31;
   localparam int NAME_W  = 64;
   localparam int RANK_W  = 4;
   localparam int DEPTH_W = $clog2(LIST_DEPTH);
   localparam int LIST_W  = (LIST_COUNT > 1) ? $clog2(LIST_COUNT) : 1;

   // Rank reported when an insert does not enter the list, saturated to the field.
   localparam logic [RANK_W-1:0] NOT_PLACED_RANK =
      RANK_W'((LIST_DEPTH > 15) ? 15 : LIST_DEPTH);

   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_READ   = 1'b1;

   typedef struct packed {
      logic               req_type;
      logic [1:0]         list_select;
      logic [SCORE_W-1:0] new_score;
      logic [NAME_W-1:0]  new_name;
      logic [2:0]         read_index;
   } req_item_type;

   typedef struct packed {
      logic               placed;
      logic [RANK_W-1:0]  rank;
      logic [SCORE_W-1:0] out_score;
      logic [NAME_W-1:0]  out_name;
   } rsp_item_type;

   typedef struct packed {
      logic [SCORE_W-1:0] score;
      logic [NAME_W-1:0]  name;
   } entry_type;

   // Entry travelling down the cell chain during an insert.
   typedef struct packed {
      logic      valid;
      logic      shift;
      entry_type entry;
   } carry_type;

   function automatic logic [NAME_W-1:0] default_name(input logic [2:0] list_num);
      logic [NAME_W-1:0] result;
      case (list_num)
         3'd0:    result = 64'h65676E696C6C6F68;
         3'd1:    result = 64'h73736F685F6E6573;
         3'd2:    result = 64'h000000686F676573;
         default: result = '0;
      endcase
      return result;
   endfunction

endpackage

### hdl/rtni_cell.sv
// One rank position of every list, linked to its neighbors in the insert chain.
// Depends on rtni_pkg.
`timescale 1ns / 1ps

module rtni_cell (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic [rtni_pkg::SCORE_W-1:0]           init_score,
   input  logic [rtni_pkg::LIST_W-1:0]            sel_list,
   input  rtni_pkg::carry_type                    up_carry,
   output rtni_pkg::carry_type                    down_carry,
   output logic                                   hit,
   output rtni_pkg::entry_type                    rd_entry
);

   rtni_pkg::entry_type entry_ff [rtni_pkg::LIST_COUNT];
   rtni_pkg::carry_type carry_ff;
   rtni_pkg::carry_type carry_in;
   rtni_pkg::entry_type cur;
   logic                take;

   always_comb begin
      cur  = entry_ff[sel_list];
      // Only the first strictly lower entry is a hit; below it every cell shifts.
      hit  = up_carry.valid && !up_carry.shift && (cur.score < up_carry.entry.score);
      take = up_carry.valid && (up_carry.shift || hit);
      if (take) begin
         carry_in.valid = 1'b1;
         carry_in.shift = 1'b1;
         carry_in.entry = cur;
      end else begin
         carry_in = up_carry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int l = 0; l < rtni_pkg::LIST_COUNT; l++) begin
            entry_ff[l].score <= init_score;
            entry_ff[l].name  <= rtni_pkg::default_name(3'(l));
         end
         carry_ff <= '0;
      end else begin
         if (take) begin
            entry_ff[sel_list] <= up_carry.entry;
         end
         carry_ff <= carry_in;
      end
   end

   assign down_carry = carry_ff;
   assign rd_entry   = cur;

endmodule

### hdl/ranked_top_n_insert.sv
// Top level of the ranked top-N insertion lists: request sequencer, cell chain
// and result register. Depends on rtni_pkg and rtni_cell.
`timescale 1ns / 1ps

// Holds LIST_COUNT score lists of LIST_DEPTH entries, sorted high to low, in a
// chain of LIST_DEPTH cells, one per rank position. A read transaction is
// answered at the clock edge that accepts it, so reads can run every cycle
// while the result register drains. An insert transaction walks the chain one
// cell per cycle; its result is registered once the walk ends and the result
// register is free, and no request is accepted meanwhile.
// An insert that beats no stored score leaves the lists unchanged and reports
// placed = 0 with rank = LIST_DEPTH.

module ranked_top_n_insert (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  rtni_pkg::req_item_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rtni_pkg::rsp_item_type rsp_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_DONE
   } state_type;

   localparam logic [rtni_pkg::DEPTH_W-1:0] LAST_STEP =
      rtni_pkg::DEPTH_W'(rtni_pkg::LIST_DEPTH - 1);

   state_type                         state_ff;
   logic [rtni_pkg::DEPTH_W-1:0]      step_ff;
   logic [rtni_pkg::DEPTH_W-1:0]      pos_ff;
   logic [rtni_pkg::LIST_W-1:0]       list_ff;
   logic                              hit_ff;
   rtni_pkg::carry_type               launch_ff;
   logic                              rsp_valid_ff;
   rtni_pkg::rsp_item_type            rsp_ff;

   rtni_pkg::carry_type               chain [rtni_pkg::LIST_DEPTH+1];
   rtni_pkg::entry_type               cell_rd [rtni_pkg::LIST_DEPTH];
   logic [rtni_pkg::LIST_DEPTH-1:0]   hit_vec;
   logic [rtni_pkg::LIST_W-1:0]       sel_list;
   logic [rtni_pkg::DEPTH_W-1:0]      rd_pos;
   rtni_pkg::entry_type               rd_entry;
   logic                              list_ok;
   logic                              read_ok;
   logic                              out_free;
   logic                              req_fire;
   logic                              hit_any;
   logic [rtni_pkg::RANK_W-1:0]       placed_rank;
   logic                              rsp_valid_in;
   logic                              launch_valid_in;

   always_comb begin
      out_free  = !rsp_valid_ff || !rsp_stall;
      req_stall = (state_ff != ST_IDLE) ||
                  (req_valid && (req_data.req_type == rtni_pkg::REQ_READ) && !out_free);
      req_fire  = req_valid && !req_stall;
      list_ok   = 32'(req_data.list_select) < rtni_pkg::LIST_COUNT;
      read_ok   = list_ok && (32'(req_data.read_index) < rtni_pkg::LIST_DEPTH);
      launch_valid_in = req_fire && (req_data.req_type == rtni_pkg::REQ_INSERT) && list_ok;
      rsp_valid_in    = (rsp_valid_ff && rsp_stall) ||
                        (req_fire && (req_data.req_type == rtni_pkg::REQ_READ)) ||
                        ((state_ff == ST_DONE) && out_free);
      // Reads only happen while idle, so the cells share one list select.
      sel_list  = (state_ff == ST_IDLE) ? rtni_pkg::LIST_W'(req_data.list_select) : list_ff;
      rd_pos    = rtni_pkg::DEPTH_W'(req_data.read_index);
      rd_entry  = cell_rd[rd_pos];
      hit_any   = |hit_vec;
      placed_rank = (32'(pos_ff) > 15) ? rtni_pkg::RANK_W'(15) : rtni_pkg::RANK_W'(pos_ff);
   end

   assign chain[0] = launch_ff;

   for (genvar p = 0; p < rtni_pkg::LIST_DEPTH; p++) begin : g_cell
      rtni_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .init_score (rtni_pkg::SCORE_W'((rtni_pkg::LIST_DEPTH - p) * rtni_pkg::SCORE_STEP)),
         .sel_list   (sel_list),
         .up_carry   (chain[p]),
         .down_carry (chain[p+1]),
         .hit        (hit_vec[p]),
         .rd_entry   (cell_rd[p])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         launch_ff.valid <= 1'b0;
         hit_ff          <= 1'b0;
      end else begin
         launch_ff.valid <= launch_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  if (req_data.req_type == rtni_pkg::REQ_READ) begin
                     rsp_ff.placed    <= read_ok;
                     rsp_ff.rank      <= {1'b0, req_data.read_index};
                     rsp_ff.out_score <= read_ok ? rd_entry.score : '0;
                     rsp_ff.out_name  <= read_ok ? rd_entry.name : '0;
                  end else begin
                     launch_ff.shift       <= 1'b0;
                     launch_ff.entry.score <= req_data.new_score;
                     launch_ff.entry.name  <= req_data.new_name;
                     list_ff               <= rtni_pkg::LIST_W'(req_data.list_select);
                     step_ff               <= '0;
                     hit_ff                <= 1'b0;
                     state_ff              <= ST_SHIFT;
                  end
               end
            end
            ST_SHIFT: begin
               if (hit_any) begin
                  hit_ff <= 1'b1;
                  pos_ff <= step_ff;
               end
               if (step_ff == LAST_STEP) begin
                  state_ff <= ST_DONE;
               end else begin
                  step_ff <= step_ff + rtni_pkg::DEPTH_W'(1);
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  rsp_ff.placed    <= hit_ff;
                  rsp_ff.rank      <= hit_ff ? placed_rank : rtni_pkg::NOT_PLACED_RANK;
                  rsp_ff.out_score <= '0;
                  rsp_ff.out_name  <= '0;
                  state_ff         <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // The insert wave leaves the last cell exactly when the sequencer finishes its walk.
   a_chain_tail: assert property (@(posedge clock) disable iff (reset)
      chain[rtni_pkg::LIST_DEPTH].valid |-> (state_ff == ST_DONE))
      else $error("insert wave left the chain outside the done state");

   // At most one cell can claim the insert position in a cycle.
   a_single_hit: assert property (@(posedge clock) disable iff (reset)
      $onehot0(hit_vec))
      else $error("more than one cell claimed the insert position");

   // A read transaction loads the result register on the next edge with its index.
   a_read_result: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_data.req_type == rtni_pkg::REQ_READ)) |=>
         (rsp_valid_ff && (rsp_ff.rank == {1'b0, $past(req_data.read_index)})))
      else $error("read result missing or wrong rank");

endmodule

### tb/testbench.sv
// Self-checking testbench for ranked_top_n_insert: directed and random insert
// and read transactions, checked against fixed expected results or a score-list predictor held here.
// Depends on rtni_pkg and the ranked_top_n_insert RTL.
`timescale 1ns / 1ps

module testbench;

   localparam int ITEM_COUNT   = 450;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 2 * (rtni_pkg::LIST_DEPTH + 1) + 5;
   localparam int TABLE_SIZE   = rtni_pkg::LIST_COUNT * rtni_pkg::LIST_DEPTH;
   localparam logic [rtni_pkg::NAME_W-1:0] RESET_NAMES [3] = '{
      64'h65676E696C6C6F68, 64'h73736F685F6E6573, 64'h000000686F676573
   };

   typedef enum int {STALL_OFF, STALL_SPARSE, STALL_TOGGLE, STALL_HEAVY} stall_mode_type;

   typedef struct {
      rtni_pkg::req_item_type req;
      bit                     typed;
      rtni_pkg::rsp_item_type rsp;
   } stim_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   rtni_pkg::req_item_type req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rtni_pkg::rsp_item_type rsp_data;

   logic [rtni_pkg::SCORE_W-1:0] score_tbl [TABLE_SIZE];
   logic [rtni_pkg::NAME_W-1:0]  name_tbl [TABLE_SIZE];
   rtni_pkg::rsp_item_type       expected_q [$];
   stim_row_type                 stim_rows [$];
   int                           err_count = 0;
   int                           cycle_count = 0;
   int                           burst_left = 0;
   stall_mode_type               stall_mode = STALL_OFF;
   int                           stall_left = 0;

   ranked_top_n_insert u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("MISMATCH %s: got %h, expected %h (cycle %0d)", what, got, want, cycle_count);
      err_count++;
   endtask

   // Applies one transaction to the predicted lists and returns its result.
   function automatic rtni_pkg::rsp_item_type apply_request(input rtni_pkg::req_item_type r);
      rtni_pkg::rsp_item_type res;
      int                     base;
      int                     pos;
      res = '0;
      if (r.req_type == rtni_pkg::REQ_READ) begin
         res.rank = rtni_pkg::RANK_W'(r.read_index);
         if (r.list_select < rtni_pkg::LIST_COUNT && r.read_index < rtni_pkg::LIST_DEPTH) begin
            base = int'(r.list_select) * rtni_pkg::LIST_DEPTH + int'(r.read_index);
            res.placed    = 1'b1;
            res.out_score = score_tbl[base];
            res.out_name  = name_tbl[base];
         end
         return res;
      end
      res.rank = rtni_pkg::NOT_PLACED_RANK;
      if (r.list_select < rtni_pkg::LIST_COUNT) begin
         base = int'(r.list_select) * rtni_pkg::LIST_DEPTH;
         pos = rtni_pkg::LIST_DEPTH;
         for (int p = 0; p < rtni_pkg::LIST_DEPTH; p++) begin
            if (pos == rtni_pkg::LIST_DEPTH && score_tbl[base + p] < r.new_score) pos = p;
         end
         if (pos < rtni_pkg::LIST_DEPTH) begin
            for (int p = rtni_pkg::LIST_DEPTH - 1; p > pos; p--) begin
               score_tbl[base + p] = score_tbl[base + p - 1];
               name_tbl[base + p]  = name_tbl[base + p - 1];
            end
            score_tbl[base + pos] = r.new_score;
            name_tbl[base + pos]  = r.new_name;
            res.placed = 1'b1;
            res.rank   = rtni_pkg::RANK_W'((pos > 15) ? 15 : pos);
         end
      end
      return res;
   endfunction

   function automatic rtni_pkg::req_item_type mk_req(input logic kind, input int list_num,
                                        input logic [rtni_pkg::SCORE_W-1:0] score,
                                        input logic [rtni_pkg::NAME_W-1:0] name,
                                        input int idx);
      rtni_pkg::req_item_type r;
      r.req_type    = kind;
      r.list_select = 2'(list_num);
      r.new_score   = score;
      r.new_name    = name;
      r.read_index  = 3'(idx);
      return r;
   endfunction

   function automatic rtni_pkg::rsp_item_type mk_rsp(input logic placed, input int rank,
                                        input logic [rtni_pkg::SCORE_W-1:0] score,
                                        input logic [rtni_pkg::NAME_W-1:0] name);
      rtni_pkg::rsp_item_type r;
      r.placed    = placed;
      r.rank      = rtni_pkg::RANK_W'(rank);
      r.out_score = score;
      r.out_name  = name;
      return r;
   endfunction

   task automatic add_row(input rtni_pkg::req_item_type rq, input bit typed,
                          input rtni_pkg::rsp_item_type rs);
      stim_row_type row;
      row.req   = rq;
      row.typed = typed;
      row.rsp   = rs;
      stim_rows.push_back(row);
   endtask

   // Most insert scores sit next to a stored score so that ties and
   // near misses happen often; the rest are small or fully random.
   function automatic rtni_pkg::req_item_type random_request();
      rtni_pkg::req_item_type       r;
      int                           l;
      int                           pick;
      logic [rtni_pkg::SCORE_W-1:0] anchor;
      r.req_type    = ($urandom_range(99) < 50) ? rtni_pkg::REQ_INSERT : rtni_pkg::REQ_READ;
      r.list_select = ($urandom_range(99) < 8) ? 2'd3 :
                      2'($urandom_range(rtni_pkg::LIST_COUNT - 1));
      r.read_index  = 3'($urandom_range(7));
      r.new_name    = {$urandom, $urandom};
      l = (r.list_select < rtni_pkg::LIST_COUNT) ? int'(r.list_select) : 0;
      pick = $urandom_range(99);
      if (pick < 12) begin
         r.new_score = rtni_pkg::SCORE_W'($urandom);
      end else if (pick < 25) begin
         r.new_score = rtni_pkg::SCORE_W'($urandom_range(20000));
      end else begin
         anchor = score_tbl[l * rtni_pkg::LIST_DEPTH + $urandom_range(rtni_pkg::LIST_DEPTH - 1)];
         case ($urandom_range(2))
            0:       r.new_score = anchor;
            1:       r.new_score = anchor + 1'b1;
            default: r.new_score = anchor - 1'b1;
         endcase
      end
      return r;
   endfunction

   // Sends one transaction, with a random gap at the start of each burst, and
   // records its expected result once it is accepted.
   task automatic drive_request(input rtni_pkg::req_item_type rq, input bit typed,
                                input rtni_pkg::rsp_item_type rs);
      rtni_pkg::rsp_item_type predicted;
      int                     gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(8, 1);
         burst_left = $urandom_range(12, 1);
         if (gap > 0) begin
            @(negedge clock) req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= rq;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = apply_request(rq);
      expected_q.push_back(typed ? rs : predicted);
   endtask

   task automatic drain_results();
      @(negedge clock) req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
   endtask

   // Receiver stall pattern: picks a new random mode after each random-length run.
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(3));
         stall_left <= $urandom_range(150, 30);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         STALL_OFF:    rsp_stall <= 1'b0;
         STALL_SPARSE: rsp_stall <= ($urandom_range(99) < 30);
         STALL_TOGGLE: rsp_stall <= ~rsp_stall;
         default:      rsp_stall <= ($urandom_range(99) < 85);
      endcase
   end

   always @(posedge clock) begin
      rtni_pkg::rsp_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            report_mismatch("result with none expected", 64'(rsp_data.rank), '0);
         end else begin
            want = expected_q.pop_front();
            if (rsp_data.placed !== want.placed)
               report_mismatch("placed", 64'(rsp_data.placed), 64'(want.placed));
            if (rsp_data.rank !== want.rank)
               report_mismatch("rank", 64'(rsp_data.rank), 64'(want.rank));
            if (rsp_data.out_score !== want.out_score)
               report_mismatch("out_score", 64'(rsp_data.out_score), 64'(want.out_score));
            if (rsp_data.out_name !== want.out_name)
               report_mismatch("out_name", rsp_data.out_name, want.out_name);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      int l;
      int p;
      for (l = 0; l < rtni_pkg::LIST_COUNT; l++) begin
         for (p = 0; p < rtni_pkg::LIST_DEPTH; p++) begin
            score_tbl[l * rtni_pkg::LIST_DEPTH + p] =
               rtni_pkg::SCORE_W'((rtni_pkg::LIST_DEPTH - p) * rtni_pkg::SCORE_STEP);
            name_tbl[l * rtni_pkg::LIST_DEPTH + p]  = (l < 3) ? RESET_NAMES[l] : '0;
         end
      end

      // Reset contents, then the edge cases: ties, the last slot, bad list.
      add_row(mk_req(rtni_pkg::REQ_READ, 0, '0, '0, 0), 1,
              mk_rsp(1'b1, 0,
                     rtni_pkg::SCORE_W'(rtni_pkg::LIST_DEPTH * rtni_pkg::SCORE_STEP),
                     RESET_NAMES[0]));
      add_row(mk_req(rtni_pkg::REQ_READ, 2, '1, '1, rtni_pkg::LIST_DEPTH - 1), 1,
              mk_rsp(1'b1, rtni_pkg::LIST_DEPTH - 1, rtni_pkg::SCORE_W'(rtni_pkg::SCORE_STEP),
                     RESET_NAMES[2]));
      add_row(mk_req(rtni_pkg::REQ_READ, 3, '0, '0, 5), 1, mk_rsp(1'b0, 5, '0, '0));
      add_row(mk_req(rtni_pkg::REQ_INSERT, 3, '1, '1, 0), 1,
              mk_rsp(1'b0, rtni_pkg::NOT_PLACED_RANK, '0, '0));
      add_row(mk_req(rtni_pkg::REQ_INSERT, 0, '0, '0, 0), 1,
              mk_rsp(1'b0, rtni_pkg::NOT_PLACED_RANK, '0, '0));
      add_row(mk_req(rtni_pkg::REQ_INSERT, 0, rtni_pkg::SCORE_W'(rtni_pkg::SCORE_STEP),
                     64'h1111, 0), 1,
              mk_rsp(1'b0, rtni_pkg::NOT_PLACED_RANK, '0, '0));
      add_row(mk_req(rtni_pkg::REQ_INSERT, 0, rtni_pkg::SCORE_W'(rtni_pkg::SCORE_STEP + 1),
                     64'h0123456789ABCDEF, 7), 1,
              mk_rsp(1'b1, rtni_pkg::LIST_DEPTH - 1, '0, '0));
      add_row(mk_req(rtni_pkg::REQ_READ, 0, '0, '0, 7), 0, '0);
      add_row(mk_req(rtni_pkg::REQ_READ, 0, '0, '0, 6), 0, '0);
      add_row(mk_req(rtni_pkg::REQ_INSERT, 1, '1, '1, 0), 1, mk_rsp(1'b1, 0, '0, '0));
      add_row(mk_req(rtni_pkg::REQ_INSERT, 1, '1, '0, 0), 1, mk_rsp(1'b1, 1, '0, '0));
      add_row(mk_req(rtni_pkg::REQ_READ, 1, '0, '0, 0), 0, '0);
      add_row(mk_req(rtni_pkg::REQ_READ, 1, '0, '0, 1), 0, '0);
      add_row(mk_req(rtni_pkg::REQ_READ, 1, '0, '0, 7), 0, '0);
      add_row(mk_req(rtni_pkg::REQ_INSERT, 2,
                     rtni_pkg::SCORE_W'(rtni_pkg::LIST_DEPTH * rtni_pkg::SCORE_STEP),
                     64'h2222, 0), 1,
              mk_rsp(1'b1, 1, '0, '0));
      add_row(mk_req(rtni_pkg::REQ_INSERT, 2, 31'd5500, 64'h3333, 2), 0, '0);
      add_row(mk_req(rtni_pkg::REQ_INSERT, 2, 31'h55555555, 64'h5555555555555555, 5), 0, '0);
      add_row(mk_req(rtni_pkg::REQ_INSERT, 2, 31'h2AAAAAAA, 64'hAAAAAAAAAAAAAAAA, 2), 0, '0);
      add_row(mk_req(rtni_pkg::REQ_READ, 2, '0, '0, 0), 0, '0);
      add_row(mk_req(rtni_pkg::REQ_READ, 2, '0, '0, 1), 0, '0);
      add_row(mk_req(rtni_pkg::REQ_READ, 2, '0, '0, 7), 0, '0);
      add_row(mk_req(rtni_pkg::REQ_READ, 3, '0, '0, 0), 1, mk_rsp(1'b0, 0, '0, '0));
      add_row(mk_req(rtni_pkg::REQ_INSERT, 0, '1, 64'h4444, 3), 1, mk_rsp(1'b1, 0, '0, '0));
      add_row(mk_req(rtni_pkg::REQ_READ, 0, '0, '0, 0), 0, '0);

      repeat (7) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      foreach (stim_rows[i]) drive_request(stim_rows[i].req, stim_rows[i].typed, stim_rows[i].rsp);
      drain_results();

      repeat (ITEM_COUNT) begin
         if ($urandom_range(99) < 2) drain_results();
         drive_request(random_request(), 1'b0, '0);
      end
      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (err_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

### ranked_top_n_insert.f
hdl/rtni_pkg.sv
hdl/rtni_cell.sv
hdl/ranked_top_n_insert.sv
tb/testbench.sv
